// ----- hw/rtl/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and character classifier of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_MISMATCH = 3'd1;
  localparam logic [2:0] ERR_EMPTY    = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } char_class_t;

  typedef struct packed {
    logic       balanced;
    logic [2:0] error_code;
  } result_t;

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    unique case (ch)
      CH_OPEN_ROUND:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
      CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_CLOSE_ROUND:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
      CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/bbc_in_if.sv -----
// ----------------------------------------------------------------------------
// bbc_in_if
// Character stream channel: valid/ready with one byte, a presence flag and an end mark.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       char_present;
  logic       end_of_string;

  modport source (output valid, output character, output char_present,
                  output end_of_string, input ready);
  modport sink (input valid, input character, input char_present,
                input end_of_string, output ready);
endinterface

// ----- hw/rtl/bbc_out_if.sv -----
// ----------------------------------------------------------------------------
// bbc_out_if
// Verdict channel: valid/ready with the balance flag and error code.
// ----------------------------------------------------------------------------
interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [2:0] error_code;

  modport source (output valid, output balanced, output error_code, input ready);
  modport sink (input valid, input balanced, input error_code, output ready);
endinterface

// ----- hw/rtl/bbc_out_skid.sv -----
// ----------------------------------------------------------------------------
// bbc_out_skid
// Two-entry output buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module bbc_out_skid
  import bbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/bracket_balance_checker_core.sv -----
// ----------------------------------------------------------------------------
// bracket_balance_checker_core
// Checks nesting of (), [] and {} in a byte stream, one verdict per string.
// ----------------------------------------------------------------------------
// One character beat is taken every clock cycle while the output buffer is
// not full. The bracket stack lives in a single-port-write, registered-read
// memory of STACK_DEPTH entries; the top of stack is held in a register, and
// after a pop the next entry comes from the memory read issued in that same
// cycle, so consecutive pops run at full rate. The verdict is registered into
// a two-entry output buffer when the end-marked beat is taken, so input can
// continue while a verdict waits. Opening past STACK_DEPTH reports overflow.
module bracket_balance_checker_core
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    chars,
  bbc_out_if.source verdict
);

  localparam int AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);

  kind_t stack_mem [STACK_DEPTH];
  kind_t rd_data;

  logic [LEVEL_W-1:0] level, level_next;
  logic [2:0]         err, err_next;
  kind_t              top_q;
  logic               top_sel;
  kind_t              top_eff;

  char_class_t cls;
  logic        accept, active, push, pop, full;
  result_t     res;

  assign accept  = chars.valid && chars.ready;
  assign chars.ready = !full;
  assign cls     = classify(chars.character);
  assign active  = accept && chars.char_present && (err == ERR_OK);
  assign top_eff = top_sel ? rd_data : top_q;

  assign push = active && cls.is_open && (level < LEVEL_W'(STACK_DEPTH));
  assign pop  = active && cls.is_close && (level != '0);

  always_comb begin
    level_next = level;
    err_next   = err;
    if (active && cls.is_open) begin
      if (push) level_next = level + LEVEL_W'(1);
      else      err_next   = ERR_OVERFLOW;
    end else if (active && cls.is_close) begin
      if (pop) begin
        level_next = level - LEVEL_W'(1);
        if (top_eff != cls.kind) err_next = ERR_MISMATCH;
      end else begin
        err_next = ERR_EMPTY;
      end
    end
    if (err_next != ERR_OK)      res.error_code = err_next;
    else if (level_next != '0)   res.error_code = ERR_UNCLOSED;
    else                         res.error_code = ERR_OK;
    res.balanced = (res.error_code == ERR_OK);
  end

  always_ff @(posedge clk) begin
    if (push) stack_mem[level[AW-1:0]] <= cls.kind;
    if (pop)  rd_data <= stack_mem[AW'(level - LEVEL_W'(2))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      err     <= ERR_OK;
      top_sel <= 1'b0;
    end else begin
      top_q   <= push ? cls.kind : top_eff;
      top_sel <= pop;
      if (accept && chars.end_of_string) begin
        level <= '0;
        err   <= ERR_OK;
      end else begin
        level <= level_next;
        err   <= err_next;
      end
    end
  end

  bbc_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && chars.end_of_string),
    .push_data (res),
    .full      (full),
    .out_valid (verdict.valid),
    .out_ready (verdict.ready),
    .out_data  ({verdict.balanced, verdict.error_code})
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && chars.end_of_string |=> level == '0 && err == ERR_OK)
    else $error("state not cleared after end of string");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && !chars.end_of_string && err != ERR_OK |=> $stable(err) && $stable(level))
    else $error("sticky error state changed");

  a_empty_close: assert property (@(posedge clk) disable iff (rst)
    active && cls.is_close && level == '0 && !chars.end_of_string |=> err == ERR_EMPTY)
    else $error("close on empty stack not flagged");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> verdict.valid)
    else $error("input stalled with no verdict pending");

endmodule

// ----- test/bracket_balance_checker_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_core_tb
// Self-checking bench for the bracket nesting checker.
// ----------------------------------------------------------------------------
// A queue of character beats feeds a clocked driver. Every accepted beat runs
// through a bit-exact predictor of the stack and sticky error. The predictor
// queues one verdict per end-marked beat. A clocked monitor compares each
// verdict beat with the oldest queued one. The stimulus has two parts.
// Directed strings cover the empty string, each bracket kind, every error
// code, and nesting to the stack limit and one past it. Random strings are
// mostly well nested, with some broken ones and some noise. The run steps
// through several idle and stall mixes, a long output hold-off, and drains
// between phases.
// ----------------------------------------------------------------------------
module bracket_balance_checker_core_tb;
  import bbc_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BEATS = 200;

  typedef struct packed {
    logic [7:0] character;
    logic       char_present;
    logic       end_of_string;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbc_in_if  chars();
  bbc_out_if verdict();

  bracket_balance_checker_core #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .verdict (verdict)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_beat_t char_q[$];
  result_t    verdict_q[$];

  kind_t       nest_stack [STACK_DEPTH];
  int unsigned nest_level = 0;
  logic [2:0]  string_err = ERR_OK;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_len = 0;
  int hold_left = 0;

  int fail_count = 0;
  int beats_sent = 0;
  int verdicts_seen = 0;
  int idle_cycles = 0;
  int code_seen [0:7] = '{default: 0};

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("MISMATCH at %0t: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    fail_count++;
  endtask

  task automatic predict_beat(input logic [7:0] ch, input logic present, input logic last);
    kind_t      k;
    logic       is_open;
    logic       is_close;
    logic [2:0] code;
    result_t    r;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_ROUND;
    case (ch)
      CH_OPEN_ROUND:   begin is_open = 1'b1;  k = KIND_ROUND;  end
      CH_OPEN_SQUARE:  begin is_open = 1'b1;  k = KIND_SQUARE; end
      CH_OPEN_CURLY:   begin is_open = 1'b1;  k = KIND_CURLY;  end
      CH_CLOSE_ROUND:  begin is_close = 1'b1; k = KIND_ROUND;  end
      CH_CLOSE_SQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
      CH_CLOSE_CURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
      default: ;
    endcase
    if (present && string_err == ERR_OK) begin
      if (is_open) begin
        if (nest_level >= STACK_DEPTH) begin
          string_err = ERR_OVERFLOW;
        end else begin
          nest_stack[nest_level] = k;
          nest_level++;
        end
      end else if (is_close) begin
        if (nest_level == 0) begin
          string_err = ERR_EMPTY;
        end else begin
          nest_level--;
          if (nest_stack[nest_level] != k) string_err = ERR_MISMATCH;
        end
      end
    end
    if (last) begin
      if (string_err != ERR_OK) code = string_err;
      else if (nest_level != 0) code = ERR_UNCLOSED;
      else code = ERR_OK;
      r = '{balanced: (code == ERR_OK), error_code: code};
      verdict_q = {verdict_q, r};
      nest_level = 0;
      string_err = ERR_OK;
    end
  endtask

  function automatic logic [7:0] open_char(input kind_t k);
    case (k)
      KIND_ROUND:  return CH_OPEN_ROUND;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      default:     return CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input kind_t k);
    case (k)
      KIND_ROUND:  return CH_CLOSE_ROUND;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      default:     return CH_CLOSE_CURLY;
    endcase
  endfunction

  function automatic kind_t any_kind();
    return kind_t'($urandom_range(2));
  endfunction

  task automatic put(input logic [7:0] ch, input logic present, input logic last);
    char_beat_t b;
    b = '{character: ch, char_present: present, end_of_string: last};
    char_q = {char_q, b};
  endtask

  // one string: deep nest, well nested, broken, or noise; random ending form
  task automatic gen_string();
    logic [7:0] text[$];
    kind_t      open_kinds[$];
    int         style;
    int         len;
    int         pos;
    bit         end_on_char;
    style = $urandom_range(99);
    if (style < 6) begin
      len = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 3);
      repeat (len) begin
        open_kinds = {open_kinds, any_kind()};
        text = {text, open_char(open_kinds[$])};
      end
      while (open_kinds.size() > 0) begin
        text = {text, close_char(open_kinds[$])};
        open_kinds.delete(open_kinds.size() - 1);
      end
    end else if (style < 85) begin
      len = $urandom_range(12);
      repeat (len) begin
        case ($urandom_range(2))
          0: begin
            open_kinds = {open_kinds, any_kind()};
            text = {text, open_char(open_kinds[$])};
          end
          1: begin
            if (open_kinds.size() > 0) begin
              text = {text, close_char(open_kinds[$])};
              open_kinds.delete(open_kinds.size() - 1);
            end else begin
              text = {text, 8'($urandom_range(255))};
            end
          end
          default: text = {text, 8'($urandom_range(255))};
        endcase
      end
      while (open_kinds.size() > 0) begin
        text = {text, close_char(open_kinds[$])};
        open_kinds.delete(open_kinds.size() - 1);
      end
      if (style >= 70 && text.size() > 0) begin
        pos = $urandom_range(text.size() - 1);
        case ($urandom_range(2))
          0: text[pos] = close_char(any_kind());
          1: text.insert(pos, close_char(any_kind()));
          default: text.delete(pos);
        endcase
      end
    end else begin
      len = $urandom_range(10);
      repeat (len) begin
        if ($urandom_range(3) == 0) text = {text, 8'($urandom_range(255))};
        else if ($urandom_range(1) == 0) text = {text, open_char(any_kind())};
        else text = {text, close_char(any_kind())};
      end
    end
    end_on_char = (text.size() > 0) && ($urandom_range(1) == 0);
    foreach (text[i]) begin
      if ($urandom_range(9) == 0) put(8'($urandom_range(255)), 1'b0, 1'b0);
      put(text[i], 1'b1, end_on_char && (i == text.size() - 1));
    end
    if (!end_on_char) put(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic fill_beats(input int count);
    int target;
    target = char_q.size() + count;
    while (char_q.size() < target) gen_string();
  endtask

  task automatic drain();
    while (char_q.size() > 0 || chars.valid || verdict_q.size() > 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive_chars
    char_beat_t nb;
    if (rst) begin
      chars.valid         <= 1'b0;
      chars.character     <= 8'h00;
      chars.char_present  <= 1'b0;
      chars.end_of_string <= 1'b0;
    end else begin
      if (chars.valid && chars.ready) begin
        predict_beat(chars.character, chars.char_present, chars.end_of_string);
        beats_sent++;
      end
      if (!chars.valid || chars.ready) begin
        if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = char_q.pop_front();
          chars.valid         <= 1'b1;
          chars.character     <= nb.character;
          chars.char_present  <= nb.char_present;
          chars.end_of_string <= nb.end_of_string;
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output back-pressure
  always @(posedge clk) begin : check_verdicts
    result_t want;
    if (rst) begin
      verdict.ready <= 1'b0;
      hold_left     <= 0;
    end else begin
      if (verdict.valid && verdict.ready) begin
        verdicts_seen++;
        code_seen[verdict.error_code]++;
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with none pending, code", -1, verdict.error_code);
        end else begin
          want = verdict_q.pop_front();
          if (verdict.balanced !== want.balanced)
            report_mismatch("balanced", want.balanced, verdict.balanced);
          if (verdict.error_code !== want.error_code)
            report_mismatch("error_code", want.error_code, verdict.error_code);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen     <= hold_req;
        hold_left     <= hold_len;
        verdict.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        verdict.ready <= 1'b0;
      end else begin
        verdict.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (chars.valid && chars.ready) || (verdict.valid && verdict.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed strings
    put(8'h00, 1'b0, 1'b1);
    put(8'hFF, 1'b0, 1'b1);
    put(CH_OPEN_ROUND, 1'b1, 1'b0);
    put(CH_CLOSE_ROUND, 1'b1, 1'b1);
    put(CH_OPEN_SQUARE, 1'b1, 1'b0);
    put(CH_OPEN_CURLY, 1'b1, 1'b0);
    put(CH_CLOSE_CURLY, 1'b1, 1'b0);
    put(CH_CLOSE_SQUARE, 1'b1, 1'b1);
    put(8'h00, 1'b1, 1'b0);
    put(8'hFF, 1'b1, 1'b0);
    put(8'h00, 1'b0, 1'b1);
    put(CH_OPEN_ROUND, 1'b1, 1'b0);
    put(CH_CLOSE_SQUARE, 1'b1, 1'b1);
    put(CH_CLOSE_CURLY, 1'b1, 1'b0);
    put(CH_OPEN_ROUND, 1'b1, 1'b1);
    put(CH_OPEN_ROUND, 1'b1, 1'b0);
    put(8'h00, 1'b0, 1'b1);
    put(CH_OPEN_CURLY, 1'b1, 1'b1);
    put(CH_OPEN_ROUND, 1'b0, 1'b0);
    put(CH_CLOSE_ROUND, 1'b0, 1'b1);
    for (int d = STACK_DEPTH; d <= STACK_DEPTH + 1; d++) begin
      for (int i = 0; i < d; i++) put(open_char(kind_t'(i % 3)), 1'b1, 1'b0);
      for (int i = d - 1; i >= 0; i--) put(close_char(kind_t'(i % 3)), 1'b1, 1'b0);
      put(8'h00, 1'b0, 1'b1);
    end
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  fill_beats(PHASE_BEATS); drain();
    send_idle_pct = 87; recv_stall_pct = 0;  fill_beats(PHASE_BEATS); drain();
    send_idle_pct = 0;  recv_stall_pct = 87; fill_beats(PHASE_BEATS); drain();
    send_idle_pct = 16; recv_stall_pct = 16; fill_beats(PHASE_BEATS); drain();

    // long output hold-off while input keeps coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 400;
    hold_req = hold_req + 1;
    fill_beats(150);
    drain();

    repeat (10) @(posedge clk);
    while (verdict_q.size() > 0) begin
      report_mismatch("verdict never arrived, code", verdict_q[0].error_code, -1);
      void'(verdict_q.pop_front());
    end
    $display("Covered %0d character beats and %0d verdicts under mixed idle and stall.",
             beats_sent, verdicts_seen);
    $display("Verdict codes: ok %0d, mismatch %0d, empty %0d, unclosed %0d, overflow %0d",
             code_seen[ERR_OK], code_seen[ERR_MISMATCH], code_seen[ERR_EMPTY],
             code_seen[ERR_UNCLOSED], code_seen[ERR_OVERFLOW]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_in_if.sv
hw/rtl/bbc_out_if.sv
hw/rtl/bbc_out_skid.sv
hw/rtl/bracket_balance_checker_core.sv
test/bracket_balance_checker_core_tb.sv
